// ===== rtl/otq_pkg.sv =====
// Shared constants, codes and types of the ordered timer queue.
`default_nettype none
package otq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int MAX_OUT    = 16;
   localparam int TIME_BITS  = 48;
   localparam int ID_BITS    = 8;
   localparam int DELAY_BITS = 32;
   localparam int IDX_W      = $clog2(NUM_TIMERS);
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int OUT_W      = $clog2(MAX_OUT + 1);
   localparam int LIST_W     = $clog2(MAX_OUT);

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACK       = 2'd0,
      KIND_EXPIRED   = 2'd1,
      KIND_IDLE_TICK = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_FULL       = 2'd1,
      STAT_DUP        = 2'd2,
      STAT_NOT_ACTIVE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_REARM,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  timer_id;
      logic [31:0] delay_us;
      logic        repeat_flag;
      logic [47:0] now_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  expired_id;
      logic [1:0]  status;
      logic        earliest_changed;
      logic        has_next;
      logic [47:0] next_deadline;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [TIME_BITS-1:0]  deadline;
      logic [DELAY_BITS-1:0] interval;
      logic                  rep;
   } entry_type;

   typedef struct packed {
      logic             place_en;
      logic             drop_en;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] look_idx;
   } slot_cmd_type;

   typedef struct packed {
      logic             look_valid;
      logic [IDX_W-1:0] look_rank;
      logic             full;
      logic [IDX_W-1:0] free_idx;
   } slot_stat_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                   input logic [DELAY_BITS-1:0] d);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, t} + (TIME_BITS + 1)'(d);
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/otq_chan_if.sv =====
// Valid/ready channel interfaces for request and response words.
`default_nettype none
interface otq_req_if;
   import otq_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface otq_rsp_if;
   import otq_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/otq_ram.sv =====
// Timer entry memory: one write port, one registered read port.
`default_nettype none
module otq_ram (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [otq_pkg::IDX_W-1:0] wr_idx,
   input  wire otq_pkg::entry_type    wr_data,
   input  wire logic                  rd_en,
   input  wire logic [otq_pkg::IDX_W-1:0] rd_idx,
   output otq_pkg::entry_type         rd_data_ff
);
   import otq_pkg::*;

   entry_type mem [NUM_TIMERS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/otq_slots.sv =====
// Slot occupancy, insertion ranks and free-slot search.
`default_nettype none
module otq_slots (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire otq_pkg::slot_cmd_type cmd,
   output otq_pkg::slot_stat_type    stat
);
   import otq_pkg::*;

   logic [NUM_TIMERS-1:0] valid_ff;
   logic [IDX_W-1:0]      rank_ff [NUM_TIMERS];
   logic [CNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]      free_idx;

   always_comb begin
      free_idx = '0;
      for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_idx = IDX_W'(k);
         end
      end
   end

   always_comb begin
      stat.look_valid = valid_ff[cmd.look_idx];
      stat.look_rank  = rank_ff[cmd.look_idx];
      stat.full       = (count_ff == CNT_W'(NUM_TIMERS));
      stat.free_idx   = free_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.place_en) begin
         valid_ff[cmd.idx] <= 1'b1;
         rank_ff[cmd.idx]  <= count_ff[IDX_W-1:0];
         count_ff          <= count_ff + 1'b1;
      end else if (cmd.drop_en) begin
         valid_ff[cmd.idx] <= 1'b0;
         for (int j = 0; j < NUM_TIMERS; j++) begin
            if (valid_ff[j] && rank_ff[j] > rank_ff[cmd.idx]) begin
               rank_ff[j] <= rank_ff[j] - 1'b1;
            end
         end
         count_ff <= count_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/otq_ctrl.sv =====
// Sequencer: table scans, add/cancel/tick decisions, re-arm and response register.
`default_nettype none
module otq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   otq_req_if.sink                    req_ch,
   otq_rsp_if.source                  rsp_ch,
   output otq_pkg::slot_cmd_type      slot_cmd,
   input  wire otq_pkg::slot_stat_type slot_stat,
   output logic                       ram_wr_en,
   output logic [otq_pkg::IDX_W-1:0]  ram_wr_idx,
   output otq_pkg::entry_type         ram_wr_data,
   output logic                       ram_rd_en,
   output logic [otq_pkg::IDX_W-1:0]  ram_rd_idx,
   input  wire otq_pkg::entry_type    ram_rd_data
);
   import otq_pkg::*;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [IDX_W-1:0]      scan_addr_ff, scan_addr_in;
   logic                  scan_issue_ff, scan_issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  final_ff, final_in;
   logic                  best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]      best_rank_ff, best_rank_in;
   entry_type             best_ff, best_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic [OUT_W-1:0]      n_ff, n_in;
   logic [OUT_W-1:0]      pos_ff, pos_in;
   logic [ID_BITS-1:0]    list_id_ff [MAX_OUT];
   logic [DELAY_BITS-1:0] list_iv_ff [MAX_OUT];
   logic [MAX_OUT-1:0]    list_rep_ff;
   logic                  list_wr;
   status_type            status_ff, status_in;
   logic                  ec_ff, ec_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  scan_done;
   logic                  better;
   logic                  match;
   logic                  expire;
   logic                  rsp_free;
   logic                  multi;
   logic                  emit_last;
   logic [ID_BITS-1:0]    req_id;
   logic [TIME_BITS-1:0]  add_dl;
   logic [LIST_W-1:0]     pos_sel;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.data  = rsp_data_ff;
   assign rsp_free     = !rsp_vld_ff || rsp_ch.ready;
   assign req_id       = req_ff.timer_id[ID_BITS-1:0];
   assign add_dl       = sat_add(req_ff.now_us[TIME_BITS-1:0], req_ff.delay_us);
   assign pos_sel      = pos_ff[LIST_W-1:0];
   assign scan_done    = rd_vld_ff && (rd_idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign expire       = best_vld_ff && (best_ff.deadline < req_ff.now_us[TIME_BITS-1:0])
                         && (n_ff < OUT_W'(MAX_OUT));
   assign multi        = (req_ff.opcode == OP_TICK) && (n_ff != '0);
   assign emit_last    = !multi || (pos_ff == n_ff - 1'b1);
   assign ram_rd_en    = scan_issue_ff;
   assign ram_rd_idx   = scan_addr_ff;

   always_comb begin
      better = rd_vld_ff && slot_stat.look_valid &&
               (!best_vld_ff || ram_rd_data.deadline < best_ff.deadline ||
                (ram_rd_data.deadline == best_ff.deadline &&
                 slot_stat.look_rank < best_rank_ff));
      match  = rd_vld_ff && slot_stat.look_valid && (ram_rd_data.id == req_id);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = final_ff ? S_EMIT : S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (req_ff.opcode)
               OP_ADD: state_in = (found_ff || slot_stat.full) ? S_EMIT : S_SCAN;
               OP_CANCEL: state_in = found_ff ? S_SCAN : S_EMIT;
               OP_TICK: begin
                  if (expire) begin
                     state_in = S_SCAN;
                  end else if (n_ff == '0) begin
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_REARM;
                  end
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_REARM: begin
            if (pos_ff == n_ff) begin
               state_in = S_SCAN;
            end
         end
         S_EMIT: begin
            if (rsp_free && emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      scan_addr_in  = scan_addr_ff;
      scan_issue_in = scan_issue_ff;
      rd_vld_in     = scan_issue_ff;
      rd_idx_in     = scan_addr_ff;
      final_in      = final_ff;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_rank_in  = best_rank_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      n_in          = n_ff;
      pos_in        = pos_ff;
      list_wr       = 1'b0;
      status_in     = status_ff;
      ec_in         = ec_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      slot_cmd      = '0;
      slot_cmd.look_idx = rd_idx_ff;
      ram_wr_en     = 1'b0;
      ram_wr_idx    = slot_stat.free_idx;
      ram_wr_data   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_ch.data;
               n_in      = '0;
               status_in = STAT_OK;
               ec_in     = 1'b0;
               final_in  = 1'b0;
            end
         end
         S_SCAN: begin
            if (scan_issue_ff) begin
               scan_issue_in = (scan_addr_ff != IDX_W'(NUM_TIMERS - 1));
               scan_addr_in  = scan_addr_ff + 1'b1;
            end
            if (better) begin
               best_vld_in  = 1'b1;
               best_idx_in  = rd_idx_ff;
               best_rank_in = slot_stat.look_rank;
               best_in      = ram_rd_data;
            end
            if (match) begin
               found_in     = 1'b1;
               found_idx_in = rd_idx_ff;
            end
            if (scan_done) begin
               pos_in = '0;
            end
         end
         S_DECIDE: begin
            final_in = 1'b1;
            case (req_ff.opcode)
               OP_ADD: begin
                  if (found_ff) begin
                     status_in = STAT_DUP;
                  end else if (slot_stat.full) begin
                     status_in = STAT_FULL;
                  end else begin
                     ram_wr_en         = 1'b1;
                     ram_wr_data.id    = req_id;
                     ram_wr_data.deadline = add_dl;
                     ram_wr_data.interval = req_ff.delay_us;
                     ram_wr_data.rep   = req_ff.repeat_flag;
                     slot_cmd.place_en = 1'b1;
                     slot_cmd.idx      = slot_stat.free_idx;
                     ec_in = !best_vld_ff || (add_dl < best_ff.deadline);
                  end
               end
               OP_CANCEL: begin
                  if (found_ff) begin
                     slot_cmd.drop_en = 1'b1;
                     slot_cmd.idx     = found_idx_ff;
                  end else begin
                     status_in = STAT_NOT_ACTIVE;
                  end
               end
               OP_TICK: begin
                  if (expire) begin
                     list_wr          = 1'b1;
                     slot_cmd.drop_en = 1'b1;
                     slot_cmd.idx     = best_idx_ff;
                     n_in             = n_ff + 1'b1;
                     final_in         = 1'b0;
                  end
               end
               default: begin
               end
            endcase
            pos_in = '0;
         end
         S_REARM: begin
            if (pos_ff != n_ff) begin
               if (list_rep_ff[pos_sel] && !slot_stat.full) begin
                  ram_wr_en            = 1'b1;
                  ram_wr_data.id       = list_id_ff[pos_sel];
                  ram_wr_data.deadline = sat_add(req_ff.now_us[TIME_BITS-1:0],
                                                 list_iv_ff[pos_sel]);
                  ram_wr_data.interval = list_iv_ff[pos_sel];
                  ram_wr_data.rep      = 1'b1;
                  slot_cmd.place_en    = 1'b1;
                  slot_cmd.idx         = slot_stat.free_idx;
               end
               pos_in = pos_ff + 1'b1;
            end else begin
               final_in = 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_vld_in                   = 1'b1;
               rsp_data_in                  = '0;
               rsp_data_in.last             = emit_last;
               if (multi) begin
                  rsp_data_in.kind       = KIND_EXPIRED;
                  rsp_data_in.expired_id = 8'(list_id_ff[pos_sel]);
               end else begin
                  rsp_data_in.kind = (req_ff.opcode == OP_TICK) ? KIND_IDLE_TICK : KIND_ACK;
                  rsp_data_in.status           = status_ff;
                  rsp_data_in.earliest_changed = ec_ff;
               end
               if (emit_last && best_vld_ff) begin
                  rsp_data_in.has_next      = 1'b1;
                  rsp_data_in.next_deadline = 48'(best_ff.deadline);
               end
               pos_in = pos_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (state_ff != S_SCAN && state_in == S_SCAN) begin
         scan_addr_in  = '0;
         scan_issue_in = 1'b1;
         best_vld_in   = 1'b0;
         found_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_issue_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_issue_ff <= scan_issue_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      final_ff     <= final_in;
      best_vld_ff  <= best_vld_in;
      best_idx_ff  <= best_idx_in;
      best_rank_ff <= best_rank_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      n_ff         <= n_in;
      pos_ff       <= pos_in;
      status_ff    <= status_in;
      ec_ff        <= ec_in;
      rsp_data_ff  <= rsp_data_in;
      if (list_wr) begin
         list_id_ff[n_ff[LIST_W-1:0]]  <= best_ff.id;
         list_iv_ff[n_ff[LIST_W-1:0]]  <= best_ff.interval;
         list_rep_ff[n_ff[LIST_W-1:0]] <= best_ff.rep;
      end
   end

`ifndef SYNTHESIS
   a_no_place_and_drop: assert property (@(posedge clock) disable iff (reset)
      !(slot_cmd.place_en && slot_cmd.drop_en))
      else $error("place and drop in the same cycle");
   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      slot_cmd.place_en |-> !slot_stat.full)
      else $error("place into a full table");
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == S_SCAN)
      else $error("read data outside a scan");
   a_expiry_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> n_ff <= OUT_W'(MAX_OUT))
      else $error("expiry count over limit");
`endif

endmodule
`default_nettype wire

// ===== rtl/ordered_timer_queue.sv =====
// Top level of the ordered timer queue: entry memory, slot table and sequencer.
// Each table scan reads one memory entry a cycle.
// Add, cancel and the unused opcode take one or two table scans before their response word.
// A tick with k > 0 expiries takes k + 2 scans, a re-arm pass and k words out; none: one scan.
// One request is in flight at a time; a new one is taken while the last word waits.
// Synchronous reset clears the slot valid bits and count directly; no clearing pass.
`default_nettype none
module ordered_timer_queue (
   input wire logic  clock,
   input wire logic  reset,
   otq_req_if.sink   req_ch,
   otq_rsp_if.source rsp_ch
);
   import otq_pkg::*;

   slot_cmd_type     slot_cmd;
   slot_stat_type    slot_stat;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_idx;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_idx;
   entry_type        ram_rd_data;

   otq_ram u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_idx     (ram_wr_idx),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_idx     (ram_rd_idx),
      .rd_data_ff (ram_rd_data)
   );

   otq_slots u_slots (
      .clock (clock),
      .reset (reset),
      .cmd   (slot_cmd),
      .stat  (slot_stat)
   );

   otq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .slot_cmd    (slot_cmd),
      .slot_stat   (slot_stat),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_idx  (ram_wr_idx),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_idx  (ram_rd_idx),
      .ram_rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

// ===== bench/otq_checker.sv =====
// Checker for the ordered timer queue: tracks the timer table and checks each response word.
`default_nettype none
module otq_checker
   import otq_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input req_type   req_data,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input rsp_type   rsp_data,
   output int       fail_count,
   output int       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic                  tv_valid [NUM_TIMERS];
   logic [ID_BITS-1:0]    tv_id [NUM_TIMERS];
   logic [TIME_BITS-1:0]  tv_deadline [NUM_TIMERS];
   logic [DELAY_BITS-1:0] tv_interval [NUM_TIMERS];
   logic                  tv_rep [NUM_TIMERS];
   int                    tv_rank [NUM_TIMERS];

   rsp_type expected_words[$];

   assign pending_count = expected_words.size();

   function automatic logic [TIME_BITS-1:0] clamp_sum(logic [TIME_BITS-1:0] t,
                                                      logic [DELAY_BITS-1:0] d);
      logic [TIME_BITS:0] s;
      s = {1'b0, t} + {17'd0, d};
      return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction

   function automatic int live_timers();
      int n;
      n = 0;
      for (int k = 0; k < NUM_TIMERS; k++) if (tv_valid[k]) n++;
      return n;
   endfunction

   function automatic int slot_of(logic [ID_BITS-1:0] id);
      for (int k = 0; k < NUM_TIMERS; k++) if (tv_valid[k] && tv_id[k] == id) return k;
      return -1;
   endfunction

   function automatic int free_slot();
      for (int k = 0; k < NUM_TIMERS; k++) if (!tv_valid[k]) return k;
      return -1;
   endfunction

   function automatic int soonest();
      int b;
      b = -1;
      for (int k = 0; k < NUM_TIMERS; k++) begin
         if (!tv_valid[k]) continue;
         if (b < 0 || tv_deadline[k] < tv_deadline[b] ||
             (tv_deadline[k] == tv_deadline[b] && tv_rank[k] < tv_rank[b]))
            b = k;
      end
      return b;
   endfunction

   function automatic void retire(int k);
      tv_valid[k] = 1'b0;
      for (int j = 0; j < NUM_TIMERS; j++)
         if (tv_valid[j] && tv_rank[j] > tv_rank[k]) tv_rank[j]--;
   endfunction

   function automatic void arm(int k, logic [ID_BITS-1:0] id, logic [TIME_BITS-1:0] dl,
                               logic [DELAY_BITS-1:0] iv, logic rep);
      tv_rank[k] = live_timers();
      tv_id[k] = id;
      tv_deadline[k] = dl;
      tv_interval[k] = iv;
      tv_rep[k] = rep;
      tv_valid[k] = 1'b1;
   endfunction

   function automatic void push_word(kind_type kind, logic [7:0] id, status_type st,
                                     logic ec, logic fin);
      rsp_type w;
      int e;
      e = fin ? soonest() : -1;
      w.kind = kind;
      w.expired_id = id;
      w.status = st;
      w.earliest_changed = ec;
      w.has_next = e >= 0;
      w.next_deadline = e >= 0 ? tv_deadline[e] : '0;
      w.last = fin;
      expected_words.push_back(w);
   endfunction

   function automatic void predict_request(req_type r);
      logic [ID_BITS-1:0]    ids [MAX_OUT];
      logic [DELAY_BITS-1:0] ivs [MAX_OUT];
      logic                  reps [MAX_OUT];
      logic [TIME_BITS-1:0]  dl;
      int n, k, e;
      logic ec;
      case (op_type'(r.opcode))
         OP_ADD: begin
            if (slot_of(r.timer_id) >= 0) begin
               push_word(KIND_ACK, 8'd0, STAT_DUP, 1'b0, 1'b1);
            end else if (free_slot() < 0) begin
               push_word(KIND_ACK, 8'd0, STAT_FULL, 1'b0, 1'b1);
            end else begin
               k = free_slot();
               dl = clamp_sum(r.now_us, r.delay_us);
               e = soonest();
               ec = (e < 0) || (dl < tv_deadline[e]);
               arm(k, r.timer_id, dl, r.delay_us, r.repeat_flag);
               push_word(KIND_ACK, 8'd0, STAT_OK, ec, 1'b1);
            end
         end
         OP_CANCEL: begin
            k = slot_of(r.timer_id);
            if (k >= 0) retire(k);
            push_word(KIND_ACK, 8'd0, k >= 0 ? STAT_OK : STAT_NOT_ACTIVE, 1'b0, 1'b1);
         end
         OP_TICK: begin
            n = 0;
            while (n < MAX_OUT) begin
               e = soonest();
               if (e < 0 || tv_deadline[e] >= r.now_us) break;
               ids[n] = tv_id[e];
               ivs[n] = tv_interval[e];
               reps[n] = tv_rep[e];
               retire(e);
               n++;
            end
            for (int i = 0; i < n; i++) begin
               if (reps[i]) begin
                  k = free_slot();
                  if (k >= 0) arm(k, ids[i], clamp_sum(r.now_us, ivs[i]), ivs[i], 1'b1);
               end
            end
            if (n == 0) push_word(KIND_IDLE_TICK, 8'd0, STAT_OK, 1'b0, 1'b1);
            for (int i = 0; i < n; i++)
               push_word(KIND_EXPIRED, ids[i], STAT_OK, 1'b0, i == n - 1);
         end
         default: push_word(KIND_ACK, 8'd0, STAT_OK, 1'b0, 1'b1);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TIMERS; k++) tv_valid[k] <= 1'b0;
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected response word %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               automatic rsp_type x = expected_words.pop_front();
               automatic int bad = 0;
               if (rsp_data.kind !== x.kind) begin
                  $error("kind: expected %0d, got %0d", x.kind, rsp_data.kind); bad++;
               end
               if (rsp_data.expired_id !== x.expired_id) begin
                  $error("expired_id: expected %0d, got %0d", x.expired_id,
                         rsp_data.expired_id); bad++;
               end
               if (rsp_data.status !== x.status) begin
                  $error("status: expected %0d, got %0d", x.status, rsp_data.status); bad++;
               end
               if (rsp_data.earliest_changed !== x.earliest_changed) begin
                  $error("earliest_changed: expected %0d, got %0d", x.earliest_changed,
                         rsp_data.earliest_changed); bad++;
               end
               if (rsp_data.has_next !== x.has_next) begin
                  $error("has_next: expected %0d, got %0d", x.has_next,
                         rsp_data.has_next); bad++;
               end
               if (rsp_data.next_deadline !== x.next_deadline) begin
                  $error("next_deadline: expected %0d, got %0d", x.next_deadline,
                         rsp_data.next_deadline); bad++;
               end
               if (rsp_data.last !== x.last) begin
                  $error("last: expected %0d, got %0d", x.last, rsp_data.last); bad++;
               end
               if (bad != 0) fail_count <= fail_count + 1;
            end
         end
         if (req_valid && req_ready) predict_request(req_data);
      end
   end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the ordered timer queue bench: clock, reset, request stimulus and verdict.
`default_nettype none
module testbench;
   import otq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   logic calm;
   logic [TIME_BITS-1:0] clock_us;

   otq_req_if req_ch ();
   otq_rsp_if rsp_ch ();

   ordered_timer_queue dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   otq_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 23);
      end
   end

   task automatic send_word(op_type op, logic [7:0] id, logic [31:0] delay, logic rep,
                            logic [47:0] now);
      if (!calm) begin
         while ($urandom_range(99) < 23) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= '{opcode: op, timer_id: id, delay_us: delay, repeat_flag: rep,
                       now_us: now};
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic random_word();
      int pick;
      logic [31:0] d;
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0: d = $urandom_range(40);
         1: d = $urandom_range(400);
         2: d = $urandom();
         default: d = 32'hFFFF_FFFF;
      endcase
      if (pick < 45) begin
         send_word(OP_ADD, 8'($urandom_range(23)), d, 1'($urandom), clock_us);
      end else if (pick < 60) begin
         send_word(OP_CANCEL, 8'($urandom_range(23)), 32'($urandom), 1'($urandom),
                   clock_us);
      end else if (pick < 95) begin
         clock_us = clock_us + $urandom_range(120);
         send_word(OP_TICK, 8'($urandom), 32'($urandom), 1'($urandom), clock_us);
      end else if (pick < 98) begin
         send_word(OP_ADD, 8'($urandom), 32'($urandom), 1'($urandom), 48'($urandom));
      end else begin
         send_word(OP_NOP, 8'($urandom), 32'($urandom), 1'($urandom),
                   {16'($urandom), 32'($urandom)});
      end
   endtask

   initial begin
      int guard;
      reset = 1'b1;
      calm = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      clock_us = 48'd1000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(OP_TICK, 8'd0, 32'd0, 1'b0, 48'd0);
      send_word(OP_ADD, 8'd255, 32'd0, 1'b1, 48'd100);
      send_word(OP_ADD, 8'd255, 32'd5, 1'b0, 48'd100);
      send_word(OP_ADD, 8'd0, 32'd0, 1'b0, 48'd100);
      send_word(OP_ADD, 8'd7, 32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFF0);
      send_word(OP_CANCEL, 8'd7, 32'd0, 1'b0, 48'd100);
      send_word(OP_CANCEL, 8'd7, 32'd0, 1'b0, 48'd100);
      send_word(OP_NOP, 8'hAA, 32'h5555_5555, 1'b1, 48'hAAAA_AAAA_AAAA);
      for (int i = 1; i <= 16; i++)
         send_word(OP_ADD, 8'(i), 32'(i % 3), 1'(i % 2), 48'd200);
      send_word(OP_TICK, 8'd0, 32'd0, 1'b0, 48'hFFFF_FFFF_FFFF);
      drain();
      calm = 1'b1;
      for (int i = 1; i <= 16; i++) send_word(OP_CANCEL, 8'(i), 32'd0, 1'b0, 48'd0);
      for (int i = 0; i < 200; i++) random_word();
      drain();
      calm = 1'b0;
      for (int i = 0; i < 200; i++) random_word();

      req_ch.valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_count != 0 && guard < 200000);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/otq_pkg.sv
rtl/otq_chan_if.sv
rtl/otq_ram.sv
rtl/otq_slots.sv
rtl/otq_ctrl.sv
rtl/ordered_timer_queue.sv
bench/otq_checker.sv
bench/testbench.sv
